// ----- design/fmpc_pkg.sv -----
// package for the flap motor position controller: constants, state record type
`default_nettype none
package fmpc_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_TEST = 2'd2;
    localparam logic [1:0] MODE_RST  = 2'd3;

    localparam logic [1:0] WM_NORMAL = 2'd0;
    localparam logic [1:0] WM_SHORT  = 2'd1;
    localparam logic [1:0] WM_TEST   = 2'd2;
    localparam logic [1:0] WM_STOP   = 2'd3;

    localparam logic [3:0] ST_RESET = 4'd0;
    localparam logic [3:0] ST_WAIT  = 4'd1;
    localparam logic [3:0] ST_HALT  = 4'd2;
    localparam logic [3:0] ST_FWD   = 4'd3;
    localparam logic [3:0] ST_BWD   = 4'd4;
    localparam logic [3:0] ST_JAM   = 4'd5;
    localparam logic [3:0] ST_SHAKE = 4'd6;
    localparam logic [3:0] SS_ENTER = 4'd7;
    localparam logic [3:0] SS_FWD   = 4'd8;
    localparam logic [3:0] SS_BWD   = 4'd9;
    localparam logic [3:0] SS_FIND  = 4'd10;
    localparam logic [3:0] SS_LOSE  = 4'd11;
    localparam logic [3:0] TS_ENTER = 4'd7;
    localparam logic [3:0] TS_FWD   = 4'd8;
    localparam logic [3:0] TS_BWD   = 4'd9;
    localparam logic [3:0] TS_MID   = 4'd10;
    localparam logic [3:0] TS_END   = 4'd11;

    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_JAM     = 3'd1;
    localparam logic [2:0] F_SHAKE   = 3'd2;
    localparam logic [2:0] F_SHORT   = 3'd3;
    localparam logic [2:0] F_OPEN    = 3'd4;
    localparam logic [2:0] F_INVALID = 3'd5;

    localparam logic [1:0] DRV_HALT = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_BWD  = 2'd2;

    localparam logic [2:0] R_RUN_TIMEOUT = 3'd0;
    localparam logic [2:0] R_JAM_LIMIT   = 3'd1;
    localparam logic [2:0] R_CHANNELS    = 3'd2;
    localparam logic [2:0] R_ACCURACY    = 3'd3;
    localparam logic [2:0] R_LEAD        = 3'd4;
    localparam logic [2:0] R_SHORT_LIM   = 3'd5;
    localparam logic [2:0] R_OPEN_LIM    = 3'd6;
    localparam logic [2:0] R_SHAKE_LIM   = 3'd7;

    // per-channel state record as kept in the memory
    typedef struct packed {
        logic [7:0]  setpoint;
        logic [7:0]  last_feedback;
        logic [1:0]  work_mode;
        logic [3:0]  step_state;
        logic [2:0]  fault_code;
        logic [4:0]  test_bits;
        logic [15:0] run_timer;
        logic [15:0] dwell_timer;
        logic [7:0]  jam_count;
        logic [7:0]  recover_count;
        logic [7:0]  shake_count;
        logic [1:0]  wire_fault;
        logic [7:0]  fault_debounce;
    } chan_rec_t;

    localparam chan_rec_t REC_RESET = '{
        setpoint: 8'd255, last_feedback: 8'd0, work_mode: WM_STOP,
        step_state: ST_RESET, fault_code: F_NONE, test_bits: 5'd0,
        run_timer: 16'd0, dwell_timer: 16'd0, jam_count: 8'd0,
        recover_count: 8'd0, shake_count: 8'd0, wire_fault: 2'd0,
        fault_debounce: 8'd0};

endpackage
`default_nettype wire

// ----- design/flap_motor_position_controller.sv -----
// top level of the flap motor position controller
//
// channel   signals                                      direction
// in        in_valid/in_ready, mode channel feedback     in
//           target tenth_pulse
// cfg       cfg_valid/cfg_ready, cfg_index cfg_data      in
// out       out_valid/out_ready, out_channel drive       out
//           accepted fault test_flags position
//
// each transaction passes through the state memory read and then the update,
// write-back and output register load. reset marks every channel record as
// at reset through per-channel valid bits. a new transaction is taken once
// stage one is empty; while a result waits in the output register the next
// update holds in stage one and the input stalls.
`default_nettype none
module flap_motor_position_controller #(
    parameter int CHANNELS = fmpc_pkg::CHANNELS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  mode,
    input  wire  [1:0]  channel,
    input  wire  [7:0]  feedback,
    input  wire  [7:0]  target,
    input  wire         tenth_pulse,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  out_channel,
    output logic [1:0]  drive,
    output logic        accepted,
    output logic [2:0]  fault,
    output logic [4:0]  test_flags,
    output logic [7:0]  position
);
    import fmpc_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    logic [15:0] run_timeout_reg;
    logic [7:0]  jam_limit_reg;
    logic [2:0]  channels_used_reg;
    logic [3:0]  accuracy_reg;
    logic [2:0]  lead_reg;
    logic [7:0]  short_limit_reg;
    logic [7:0]  open_limit_reg;
    logic [4:0]  shake_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_timeout_reg   <= 16'd150;
            jam_limit_reg     <= 8'd4;
            channels_used_reg <= 3'd3;
            accuracy_reg      <= 4'd5;
            lead_reg          <= 3'd1;
            short_limit_reg   <= 8'd5;
            open_limit_reg    <= 8'd250;
            shake_limit_reg   <= 5'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                R_RUN_TIMEOUT: run_timeout_reg   <= cfg_data;
                R_JAM_LIMIT:   jam_limit_reg     <= cfg_data[7:0];
                R_CHANNELS:    channels_used_reg <= cfg_data[2:0];
                R_ACCURACY:    accuracy_reg      <= cfg_data[3:0];
                R_LEAD:        lead_reg          <= cfg_data[2:0];
                R_SHORT_LIM:   short_limit_reg   <= cfg_data[7:0];
                R_OPEN_LIM:    open_limit_reg    <= cfg_data[7:0];
                default:       shake_limit_reg   <= cfg_data[4:0];
            endcase
        end
    end

    // stage 1: accepted transaction waiting on the memory read
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [1:0]  s1_chan_reg;
    logic [7:0]  s1_fb_reg;
    logic [7:0]  s1_target_reg;
    logic        s1_tenth_reg;

    logic in_fire;
    logic out_free;

    // output register frees when empty or being taken
    assign out_free = !out_valid || out_ready;
    assign in_ready = !s1_valid_reg;
    assign in_fire  = in_valid && in_ready;

    logic chan_ok_in;
    assign chan_ok_in = ({1'b0, channel} < channels_used_reg) &&
                        (32'(channel) < CHANNELS);

    // state memory with registered read
    chan_rec_t mem [CHANNELS];
    chan_rec_t rd_reg;
    logic [CHANNELS-1:0] init_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    chan_rec_t   wr_data;

    always_ff @(posedge clk)
    begin
        if (in_fire && chan_ok_in)
            rd_reg <= mem[AW'(channel)];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg <= '0;
        else if (wr_en)
            init_reg[wr_addr] <= 1'b1;
    end

    logic init_s1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_s1_reg <= 1'b0;
        else if (in_fire)
            init_s1_reg <= init_reg[AW'(channel)];
    end

    logic s1_ok_reg;
    logic advance;
    assign advance = s1_valid_reg && out_free;

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg   <= mode;
            s1_chan_reg   <= channel;
            s1_fb_reg     <= feedback;
            s1_target_reg <= target;
            s1_tenth_reg  <= tenth_pulse;
            s1_ok_reg     <= chan_ok_in;
        end
    end

    // update logic
    chan_rec_t r;
    chan_rec_t n;
    logic [1:0] drv;
    logic       ok;
    logic signed [9:0] sp, dset, dpos, pos, acc, ld, sh, sl, ol;
    logic signed [9:0] tp, diff, adset, adpos;
    logic        fwd;
    logic [15:0] lim;

    always_comb
    begin
        r    = init_s1_reg ? rd_reg : REC_RESET;
        n    = r;
        drv  = DRV_HALT;
        ok   = 1'b1;
        pos  = 10'(s1_fb_reg);
        acc  = 10'(accuracy_reg);
        ld   = 10'(lead_reg);
        sh   = 10'(shake_limit_reg);
        sl   = 10'(short_limit_reg);
        ol   = 10'(open_limit_reg);
        sp   = 10'(r.setpoint);
        dset = '0;
        dpos = '0;
        adset = '0;
        adpos = '0;
        tp   = '0;
        diff = '0;
        fwd  = 1'b0;
        lim  = '0;
        case (s1_mode_reg)
            MODE_TICK:
            begin
                if (s1_tenth_reg)
                begin
                    if (n.run_timer != 16'hFFFF) n.run_timer = n.run_timer + 16'd1;
                    if (n.dwell_timer != 16'hFFFF)
                        n.dwell_timer = n.dwell_timer + 16'd1;
                end
                // setpoint clamps
                if (sp != 10'sd255)
                begin
                    if (sp < sl)
                        sp = (sl + 10'sd2 > 10'sd254) ? 10'sd254 : sl + 10'sd2;
                    if (sp > ol)
                        sp = (ol - 10'sd2 < 10'sd0) ? 10'sd0 : ol - 10'sd2;
                    n.setpoint = sp[7:0];
                end
                // wiper fault debounce
                if (s1_fb_reg > open_limit_reg || s1_fb_reg < short_limit_reg)
                begin
                    if (n.fault_debounce < 8'd5)
                        n.fault_debounce = n.fault_debounce + 8'd1;
                    else
                        n.wire_fault = (s1_fb_reg > open_limit_reg) ? 2'd2 : 2'd1;
                end
                else
                begin
                    if (n.fault_debounce != 8'd0)
                        n.fault_debounce = n.fault_debounce - 8'd1;
                    else
                        n.wire_fault = 2'd0;
                end
                dset  = pos - sp;
                dpos  = pos - 10'(r.last_feedback);
                adset = dset < 0 ? -dset : dset;
                adpos = dpos < 0 ? -dpos : dpos;
                n.last_feedback = s1_fb_reg;
                case (r.work_mode)
                    WM_NORMAL:
                    begin
                        if (sp == 10'sd255)
                            n.work_mode = WM_STOP;
                        else if (n.wire_fault != 2'd0)
                        begin
                            n.work_mode  = WM_SHORT;
                            n.step_state = SS_ENTER;
                            n.run_timer  = '0;
                            n.fault_code = (n.wire_fault == 2'd1) ? F_SHORT : F_OPEN;
                        end
                        else
                        begin
                            case (r.step_state)
                                ST_HALT:
                                begin
                                    if (adpos <= sh)
                                    begin
                                        if (adset < acc)
                                        begin
                                            n.fault_code = F_NONE;
                                            n.recover_count = '0;
                                        end
                                        else
                                            n.step_state = (dset > 0) ? ST_BWD : ST_FWD;
                                    end
                                    else
                                    begin
                                        n.fault_code = F_SHAKE;
                                        n.step_state = ST_SHAKE;
                                    end
                                end
                                ST_FWD, ST_BWD:
                                begin
                                    fwd = (r.step_state == ST_FWD);
                                    drv = fwd ? DRV_FWD : DRV_BWD;
                                    if (fwd ? (dpos < -10'sd3 || dpos > 10'sd30)
                                            : (dpos > 10'sd3 || dpos < -10'sd30))
                                    begin
                                        n.step_state = ST_HALT;
                                        drv = DRV_HALT;
                                    end
                                    if (fwd ? (dset >= -ld) : (dset < ld))
                                    begin
                                        n.step_state  = ST_WAIT;
                                        n.dwell_timer = '0;
                                        drv = DRV_HALT;
                                    end
                                    else
                                    begin
                                        lim = (r.jam_count == 8'd0) ? run_timeout_reg
                                              : 16'd20;
                                        if (n.run_timer >= lim)
                                        begin
                                            n.run_timer  = '0;
                                            n.step_state = ST_JAM;
                                            n.fault_code = F_JAM;
                                            if (n.jam_count != 8'hFF)
                                                n.jam_count = n.jam_count + 8'd1;
                                            drv = DRV_HALT;
                                        end
                                    end
                                end
                                ST_JAM:
                                begin
                                    if (adset < acc)
                                    begin
                                        n.step_state = ST_HALT;
                                        n.fault_code = F_NONE;
                                    end
                                    else if (r.jam_count >= jam_limit_reg)
                                        n.fault_code = F_JAM;
                                    else if (n.run_timer >= 16'd100)
                                    begin
                                        n.run_timer  = '0;
                                        n.step_state = (dset < 0) ? ST_FWD : ST_BWD;
                                    end
                                end
                                ST_SHAKE:
                                begin
                                    if (adpos <= sh)
                                    begin
                                        if (n.dwell_timer >= 16'd10)
                                        begin
                                            n.dwell_timer = '0;
                                            n.step_state  = ST_HALT;
                                            if (n.shake_count != 8'hFF)
                                                n.shake_count = n.shake_count + 8'd1;
                                        end
                                    end
                                    else
                                        n.dwell_timer = '0;
                                end
                                ST_RESET:
                                begin
                                    n.run_timer   = '0;
                                    n.jam_count   = '0;
                                    n.shake_count = '0;
                                    if (dset == 0)
                                    begin
                                        n.step_state = ST_HALT;
                                        n.fault_code = F_NONE;
                                    end
                                    else
                                        n.step_state = (dset < 0) ? ST_FWD : ST_BWD;
                                end
                                default:
                                begin
                                    n.step_state = ST_WAIT;
                                    if (n.dwell_timer >= 16'd5)
                                    begin
                                        n.dwell_timer = '0;
                                        n.step_state  = ST_HALT;
                                    end
                                end
                            endcase
                        end
                    end
                    WM_SHORT:
                    begin
                        case (r.step_state)
                            SS_FWD:
                            begin
                                if (n.run_timer >= 16'd20)
                                begin
                                    n.run_timer  = '0;
                                    n.step_state = SS_BWD;
                                end
                                if (n.wire_fault == 2'd0 && s1_fb_reg > 8'd51 &&
                                    s1_fb_reg < 8'd200)
                                begin
                                    n.step_state = SS_FIND;
                                    n.run_timer  = '0;
                                end
                                drv = (r.fault_code == F_SHORT) ? DRV_BWD : DRV_FWD;
                            end
                            SS_BWD:
                            begin
                                if (n.run_timer >= 16'd20)
                                begin
                                    n.run_timer = '0;
                                    if (n.wire_fault != 2'd0)
                                        n.step_state = SS_LOSE;
                                    else
                                        n.step_state = SS_FIND;
                                end
                                drv = (r.fault_code == F_SHORT) ? DRV_FWD : DRV_BWD;
                            end
                            SS_FIND:
                            begin
                                if (n.wire_fault != 2'd0) n.step_state = SS_LOSE;
                                if (n.run_timer >= 16'd5)
                                begin
                                    n.run_timer  = '0;
                                    n.step_state = ST_HALT;
                                    n.work_mode  = WM_NORMAL;
                                    n.jam_count  = '0;
                                end
                            end
                            SS_LOSE:
                            begin
                                if (n.wire_fault == 2'd0)
                                begin
                                    n.step_state = ST_SHAKE;
                                    n.work_mode  = WM_NORMAL;
                                    n.run_timer  = '0;
                                end
                            end
                            default:
                            begin
                                if (n.run_timer >= 16'd5)
                                begin
                                    n.run_timer = '0;
                                    if (n.wire_fault == 2'd0)
                                        n.step_state = SS_FIND;
                                    else
                                        n.step_state = (r.recover_count < 8'd3) ? SS_FWD
                                                       : SS_LOSE;
                                    if (n.recover_count != 8'hFF)
                                        n.recover_count = n.recover_count + 8'd1;
                                end
                            end
                        endcase
                    end
                    WM_TEST:
                    begin
                        case (r.step_state)
                            TS_FWD:
                            begin
                                if (dpos < -10'sd3 || dpos > 10'sd30)
                                    n.test_bits[0] = 1'b1;
                                if (n.run_timer >= 16'd100)
                                begin
                                    n.run_timer = '0;
                                    if (s1_fb_reg < 8'd10) n.test_bits[1] = 1'b1;
                                    else if (s1_fb_reg < 8'd240) n.test_bits[2] = 1'b1;
                                    n.step_state = TS_BWD;
                                end
                                drv = DRV_FWD;
                            end
                            TS_BWD:
                            begin
                                if (dpos > 10'sd3 || dpos < -10'sd30)
                                    n.test_bits[0] = 1'b1;
                                if (n.run_timer >= 16'd100)
                                begin
                                    n.run_timer = '0;
                                    if (s1_fb_reg > 8'd250) n.test_bits[1] = 1'b1;
                                    else if (s1_fb_reg > 8'd10) n.test_bits[2] = 1'b1;
                                    n.step_state = TS_MID;
                                end
                                drv = DRV_BWD;
                            end
                            TS_MID:
                            begin
                                if (pos > 10'sd128 - acc && pos < 10'sd128 + acc)
                                begin
                                    n.test_bits[3] = 1'b1;
                                    n.step_state   = TS_END;
                                end
                                else if (pos < 10'sd128) drv = DRV_FWD;
                                else if (pos > 10'sd128) drv = DRV_BWD;
                                if (n.run_timer >= 16'd100)
                                begin
                                    n.run_timer = '0;
                                    n.test_bits[4:3] = 2'b11;
                                    n.step_state = TS_END;
                                end
                                if (n.step_state == TS_END) drv = DRV_HALT;
                            end
                            TS_END:
                            begin
                                n.step_state = ST_HALT;
                                n.work_mode  = WM_NORMAL;
                            end
                            default:
                            begin
                                n.run_timer  = '0;
                                n.step_state = TS_FWD;
                                n.test_bits  = '0;
                            end
                        endcase
                    end
                    default:
                    begin
                        if (sp != 10'sd255)
                        begin
                            n.step_state = ST_SHAKE;
                            n.work_mode  = WM_NORMAL;
                            n.run_timer  = '0;
                        end
                    end
                endcase
            end
            MODE_SET:
            begin
                if (s1_target_reg == 8'd255)
                begin
                    n.setpoint = 8'd255;
                    if (r.work_mode != WM_TEST) n.work_mode = WM_STOP;
                end
                else
                begin
                    tp = 10'(s1_target_reg);
                    if (tp <= sl) tp = sl + 10'sd1;
                    if (tp >= ol) tp = ol - 10'sd1;
                    if (tp < 0) tp = '0;
                    if (tp > 10'sd254) tp = 10'sd254;
                    diff = sp - tp;
                    if (diff < 0) diff = -diff;
                    if (diff > 10'sd2)
                    begin
                        if (r.work_mode == WM_NORMAL)
                            n.step_state = ST_RESET;
                        else if (r.work_mode == WM_SHORT)
                        begin
                            if (diff > 10'sd10)
                            begin
                                n.step_state    = SS_ENTER;
                                n.recover_count = '0;
                            end
                            else
                                ok = 1'b0;
                        end
                        if (ok) n.setpoint = tp[7:0];
                    end
                end
            end
            MODE_TEST:
            begin
                n.work_mode  = WM_TEST;
                n.step_state = TS_ENTER;
            end
            default:
            begin
                n.step_state = ST_RESET;
                n.work_mode  = WM_NORMAL;
            end
        endcase
    end

    assign wr_en   = advance && s1_ok_reg;
    assign wr_addr = AW'(s1_chan_reg);
    assign wr_data = n;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_channel <= s1_chan_reg;
            if (s1_ok_reg)
            begin
                drive      <= drv;
                accepted   <= ok;
                fault      <= n.fault_code;
                test_flags <= n.test_bits;
                position   <= n.last_feedback;
            end
            else
            begin
                drive      <= DRV_HALT;
                accepted   <= 1'b0;
                fault      <= F_INVALID;
                test_flags <= '0;
                position   <= '0;
            end
        end
    end

endmodule
`default_nettype wire
